FILE: rtl/cwfr_pkg.sv
`timescale 1ns / 1ps

package cwfr_pkg;

    // Frame status codes
    typedef enum logic [1:0] {
        ERR_OK  = 2'd0,
        ERR_HDR = 2'd1,
        ERR_SUM = 2'd2,
        ERR_LEN = 2'd3
    } err_t;

    // Result kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Item function codes
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Config register map
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_SECOND = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIL_RELOAD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REINIT_THR = 8'd3;

    // Register reset values
    localparam logic [7:0] RST_HDR_FIRST  = 8'h41;
    localparam logic [7:0] RST_HDR_SECOND = 8'h4b;
    localparam logic [7:0] RST_SIL_RELOAD = 8'd20;
    localparam logic [7:0] RST_REINIT_THR = 8'd10;
    localparam logic [7:0] RST_SILENCE    = 8'd20;

    // Shortest legal frame: two header bytes, length, checksum slot
    localparam logic [7:0] MIN_FRAME_LEN = 8'd4;
    localparam logic [7:0] LEN_BYTE_CNT  = 8'd3;
    localparam logic [7:0] FIRST_PAIR    = 8'd4;

    typedef struct packed {
        logic accept;     // input side may take an item
        logic recv;       // frame reception in progress
        logic rd_load;    // point pair index at first pair
        logic rd_en;      // frame buffer read
        logic rd_hi;      // read second byte of pair
        logic cap_addr;   // latch address byte from buffer
        logic emit_write; // load write item into output register
        logic rd_step;    // advance to next pair
        logic emit_stat;  // load status item into output register
    } cwfr_cmd_t;

    typedef struct packed {
        logic started;    // frame start byte taken
        logic done;       // frame ended on this item
        logic ok;         // frame passed all checks
        logic has_pair;   // another full pair remains
        logic out_free;   // output register can take a result
    } cwfr_stat_t;

endpackage

FILE: rtl/cwfr_ram.sv
`timescale 1ns / 1ps

module cwfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/cwfr_ctrl.sv
`timescale 1ns / 1ps

module cwfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  cwfr_pkg::cwfr_stat_t stat,
    output cwfr_pkg::cwfr_cmd_t  cmd
);
    import cwfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RECV,
        S_PAIR_A,
        S_PAIR_D,
        S_PAIR_W,
        S_STATUS
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE, S_RECV:
            begin
                cmd.accept = 1'b1;
                cmd.recv   = (state_reg == S_RECV);
                if (stat.done)
                begin
                    if (stat.ok)
                    begin
                        cmd.rd_load = 1'b1;
                        state_next  = S_PAIR_A;
                    end
                    else
                    begin
                        state_next = S_STATUS;
                    end
                end
                else if (stat.started)
                begin
                    state_next = S_RECV;
                end
            end
            S_PAIR_A:
            begin
                if (stat.has_pair)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_PAIR_D;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_PAIR_D:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_hi    = 1'b1;
                cmd.cap_addr = 1'b1;
                state_next   = S_PAIR_W;
            end
            S_PAIR_W:
            begin
                cmd.rd_hi = 1'b1;
                if (stat.out_free)
                begin
                    cmd.emit_write = 1'b1;
                    cmd.rd_step    = 1'b1;
                    state_next     = S_PAIR_A;
                end
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_stat = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/cwfr_dp.sv
`timescale 1ns / 1ps

module cwfr_dp #(
    parameter int MAX_FRAME = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input items
    input  logic                               in_valid,
    input  logic                               func,
    input  logic [7:0]                         rx_byte,
    input  logic                               frame_start,
    // config writes
    input  logic                               cfg_valid,
    input  logic [cwfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                         cfg_data,
    // result items
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               kind,
    output logic [7:0]                         write_addr,
    output logic [7:0]                         write_data,
    output logic [1:0]                         status_code,
    output logic                               link_reset,
    output logic                               last,
    // control
    input  cwfr_pkg::cwfr_cmd_t                cmd,
    output cwfr_pkg::cwfr_stat_t               stat
);
    import cwfr_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);
    localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME);

    // config
    logic [7:0] hdr_first_reg;
    logic [7:0] hdr_second_reg;
    logic [7:0] sil_reload_reg;
    logic [7:0] reinit_thr_reg;

    // frame state
    logic [7:0] byte_cnt_reg;
    logic [7:0] frame_len_reg;
    logic [7:0] sum_reg;
    logic [7:0] hdr0_reg;
    logic [7:0] hdr1_reg;
    logic [7:0] silence_reg;
    err_t       err_reg;
    err_t       err_next;

    // pair readout
    logic [7:0] rd_idx_reg;
    logic [7:0] addr_hold_reg;
    logic [7:0] rd_data;
    logic [7:0] rd_idx_hi;
    logic [AW-1:0] ram_raddr;

    // output register
    logic       out_valid_reg;
    logic       kind_reg;
    logic [7:0] waddr_reg;
    logic [7:0] wdata_reg;
    err_t       ecode_reg;
    logic       lreset_reg;
    logic       last_reg;

    logic       fire;
    logic       tick;
    logic       start;
    logic       take;
    logic [7:0] cnt_base;
    logic [7:0] cnt_new;
    logic [7:0] sum_new;
    logic       len_end;
    logic       frm_end;
    logic       ram_we;
    logic       out_load;

    assign fire     = in_valid & cmd.accept;
    assign tick     = fire & (func == FUNC_TICK);
    assign start    = frame_start & (func == FUNC_BYTE);
    assign take     = fire & (func == FUNC_BYTE) & (frame_start | cmd.recv);
    assign cnt_base = start ? 8'd0 : byte_cnt_reg;
    assign cnt_new  = cnt_base + 8'd1;
    assign sum_new  = (start ? 8'd0 : sum_reg) + rx_byte;
    assign len_end  = (cnt_new == LEN_BYTE_CNT) &
                      ((rx_byte < MIN_FRAME_LEN) | (rx_byte > MAX_LEN));
    assign frm_end  = (cnt_new > LEN_BYTE_CNT) & (cnt_new == frame_len_reg);
    assign ram_we   = take & (cnt_base < MAX_LEN);

    always_comb
    begin
        if (len_end)
        begin
            err_next = ERR_LEN;
        end
        else if ((hdr0_reg != hdr_first_reg) || (hdr1_reg != hdr_second_reg))
        begin
            err_next = ERR_HDR;
        end
        else if (sum_new != 8'd0)
        begin
            err_next = ERR_SUM;
        end
        else
        begin
            err_next = ERR_OK;
        end
    end

    assign rd_idx_hi = rd_idx_reg + 8'd1;
    assign ram_raddr = cmd.rd_hi ? rd_idx_hi[AW-1:0] : rd_idx_reg[AW-1:0];
    assign out_load  = cmd.emit_write | cmd.emit_stat;

    assign stat.started  = take & start;
    assign stat.done     = take & (len_end | frm_end);
    assign stat.ok       = (err_next == ERR_OK);
    assign stat.has_pair = ({1'b0, rd_idx_reg} + 9'd1) < {1'b0, frame_len_reg};
    assign stat.out_free = ~out_valid_reg | ~out_stall;

    cwfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_base[AW-1:0]),
        .wdata (rx_byte),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= RST_HDR_FIRST;
            hdr_second_reg <= RST_HDR_SECOND;
            sil_reload_reg <= RST_SIL_RELOAD;
            reinit_thr_reg <= RST_REINIT_THR;
            byte_cnt_reg   <= '0;
            frame_len_reg  <= '0;
            sum_reg        <= '0;
            silence_reg    <= RST_SILENCE;
            err_reg        <= ERR_OK;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_HDR_FIRST:  hdr_first_reg  <= cfg_data;
                    CFG_HDR_SECOND: hdr_second_reg <= cfg_data;
                    CFG_SIL_RELOAD: sil_reload_reg <= cfg_data;
                    CFG_REINIT_THR: reinit_thr_reg <= cfg_data;
                    default:        ;
                endcase
            end

            if (take)
            begin
                byte_cnt_reg <= cnt_new;
                sum_reg      <= sum_new;
                if (start)
                begin
                    frame_len_reg <= '0;
                end
                if (cnt_new == LEN_BYTE_CNT)
                begin
                    frame_len_reg <= rx_byte;
                end
            end

            if (tick && (silence_reg != 8'd0))
            begin
                silence_reg <= silence_reg - 8'd1;
            end
            else if (stat.done && stat.ok)
            begin
                silence_reg <= sil_reload_reg;
            end

            if (stat.done)
            begin
                err_reg <= err_next;
            end

            if (cmd.rd_load)
            begin
                rd_idx_reg <= FIRST_PAIR;
            end
            else if (cmd.rd_step)
            begin
                rd_idx_reg <= rd_idx_reg + 8'd2;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take && (cnt_base == 8'd0))
        begin
            hdr0_reg <= rx_byte;
        end
        if (take && (cnt_base == 8'd1))
        begin
            hdr1_reg <= rx_byte;
        end
        if (cmd.cap_addr)
        begin
            addr_hold_reg <= rd_data;
        end
        if (cmd.emit_write)
        begin
            kind_reg   <= KIND_WRITE;
            waddr_reg  <= addr_hold_reg;
            wdata_reg  <= rd_data;
            ecode_reg  <= ERR_OK;
            lreset_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else if (cmd.emit_stat)
        begin
            kind_reg   <= KIND_STATUS;
            waddr_reg  <= '0;
            wdata_reg  <= '0;
            ecode_reg  <= err_reg;
            lreset_reg <= (silence_reg < reinit_thr_reg);
            last_reg   <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign write_addr  = waddr_reg;
    assign write_data  = wdata_reg;
    assign status_code = ecode_reg;
    assign link_reset  = lreset_reg;
    assign last        = last_reg;

endmodule

FILE: rtl/checksummed_write_frame_receiver_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   func, rx_byte, frame_start
// out       source     out_valid / out_stall kind, write_addr, write_data,
//                                            status_code, link_reset, last
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Byte and tick items are accepted without a stall while no frame drains.
// At frame end the input stalls while results drain from the frame buffer:
// for each address/data pair, two buffer reads through the single read port
// and then the output load; then a check that finds no pair left, and then
// the status item. A rejected frame stalls the input only for its status
// item. Any output stall time lengthens the hold.
// Reset is asynchronous, active low; the frame buffer is not cleared.

module checksummed_write_frame_receiver_top #(
    parameter int MAX_FRAME = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // item input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [7:0]                     rx_byte,
    input  logic                           frame_start,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cwfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    // result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           kind,
    output logic [7:0]                     write_addr,
    output logic [7:0]                     write_data,
    output logic [1:0]                     status_code,
    output logic                           link_reset,
    output logic                           last
);
    import cwfr_pkg::*;

    cwfr_cmd_t  cmd;
    cwfr_stat_t stat;

    // Input is only held off while a finished frame drains.
    assign in_stall  = ~cmd.accept;
    // Register writes are always accepted and land on the next rising edge.
    assign cfg_ready = 1'b1;

    cwfr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    cwfr_dp #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .func        (func),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .write_addr  (write_addr),
        .write_data  (write_data),
        .status_code (status_code),
        .link_reset  (link_reset),
        .last        (last),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cwfr_pkg::*;

    // Frame buffer depth of the instance, also the largest legal length byte.
    localparam int FRAME_CAP     = 64;
    // Longest drain of a full frame, doubled, before a register write.
    localparam int SETTLE_CYCLES = 2 * (3 * (FRAME_CAP - 4) / 2 + 2);
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int DIR_ROWS      = 24;
    localparam int PHASE_ITEMS   = 100;
    localparam int REPORT_MAX    = 10;
    // Index past the end of the register map: the write must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hff;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic       frame_start;
    } rx_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] write_addr;
        logic [7:0] write_data;
        err_t       status_code;
        logic       link_reset;
        logic       last;
    } frame_result_t;

    // One row of the directed script. Rows with typed set carry the status
    // that the frame must end with; all other rows rely on the predictor.
    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       typed;
        err_t       code;
        logic       reset_req;
    } script_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       func = FUNC_BYTE;
    logic [7:0] rx_byte = 8'h00;
    logic       frame_start = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0] cfg_data = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       kind;
    logic [7:0] write_addr;
    logic [7:0] write_data;
    logic [1:0] status_code;
    logic       link_reset;
    logic       last;

    checksummed_write_frame_receiver_top #(
        .MAX_FRAME(FRAME_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .rx_byte(rx_byte),
        .frame_start(frame_start),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .write_addr(write_addr),
        .write_data(write_data),
        .status_code(status_code),
        .link_reset(link_reset),
        .last(last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Receiver shadow: registers, frame buffer and silence counter.
    // ------------------------------------------------------------------
    logic [7:0] hdr_first_reg   = RST_HDR_FIRST;
    logic [7:0] hdr_second_reg  = RST_HDR_SECOND;
    logic [7:0] sil_reload_reg  = RST_SIL_RELOAD;
    logic [7:0] reinit_thr_reg  = RST_REINIT_THR;
    logic [7:0] frame_buf [FRAME_CAP];
    logic [7:0] rx_count  = 8'd0;
    logic [7:0] rx_length = 8'd0;
    logic [7:0] rx_sum    = 8'd0;
    logic       receiving = 1'b0;
    logic [7:0] silence   = RST_SILENCE;

    frame_result_t step_results [$];   // results caused by the latest item
    frame_result_t results_due [$];    // in flight, oldest first

    int send_gap_pct   = 0;
    int stall_pct      = 0;
    int live_items     = 0;   // items that were not simply dropped
    int fail_count     = 0;
    int reported       = 0;
    int writes_seen    = 0;
    int resets_seen    = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    script_row_t dir_script [0:DIR_ROWS-1] = '{
        // tick with frame_start set: start must be ignored
        '{FUNC_TICK, 8'h00, 1'b1, 1'b0, ERR_OK,  1'b0},
        // byte while idle, no start: dropped
        '{FUNC_BYTE, 8'hff, 1'b0, 1'b0, ERR_OK,  1'b0},
        // bad header and length 3: length wins
        '{FUNC_BYTE, 8'h00, 1'b1, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, 8'h00, 1'b0, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, 8'h03, 1'b0, 1'b1, ERR_LEN, 1'b0},
        // length 255, far over the buffer
        '{FUNC_BYTE, RST_HDR_FIRST,  1'b1, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, RST_HDR_SECOND, 1'b0, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, 8'hff, 1'b0, 1'b1, ERR_LEN, 1'b0},
        // bad first header byte and bad sum: header wins
        '{FUNC_BYTE, 8'h00, 1'b1, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, RST_HDR_SECOND, 1'b0, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, 8'h04, 1'b0, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, 8'h00, 1'b0, 1'b1, ERR_HDR, 1'b0},
        // good header, sum off
        '{FUNC_BYTE, RST_HDR_FIRST,  1'b1, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, RST_HDR_SECOND, 1'b0, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, 8'h04, 1'b0, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, 8'h00, 1'b0, 1'b1, ERR_SUM, 1'b0},
        // one-byte frame, dropped by the restart that follows
        '{FUNC_BYTE, 8'h12, 1'b1, 1'b0, ERR_OK,  1'b0},
        // length 7: one write ff -> 00, trailing ee has no partner
        '{FUNC_BYTE, RST_HDR_FIRST,  1'b1, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, RST_HDR_SECOND, 1'b0, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, 8'h07, 1'b0, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, 8'h80, 1'b0, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, 8'hff, 1'b0, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, 8'h00, 1'b0, 1'b0, ERR_OK,  1'b0},
        '{FUNC_BYTE, 8'hee, 1'b0, 1'b0, ERR_OK,  1'b0}
    };

    // End of frame: good frames reload the silence counter and unload their
    // address/data pairs, every frame gets one status item.
    function automatic void close_frame(err_t code);
        frame_result_t res;
        if (code == ERR_OK) begin
            silence = sil_reload_reg;
            for (int i = FIRST_PAIR; i + 1 < rx_length && i + 1 < FRAME_CAP; i += 2) begin
                res = '{KIND_WRITE, frame_buf[i], frame_buf[i + 1], ERR_OK, 1'b0, 1'b0};
                step_results.push_back(res);
            end
        end
        res = '{KIND_STATUS, 8'h00, 8'h00, code, (silence < reinit_thr_reg), 1'b1};
        step_results.push_back(res);
        receiving = 1'b0;
    endfunction

    // Advances the shadow by one item. Returns 0 when the item is dropped.
    function automatic bit receive_item(rx_item_t it);
        err_t code;
        step_results.delete();
        if (it.func == FUNC_TICK) begin
            if (silence != 8'd0)
                silence = silence - 8'd1;
            return 1'b1;
        end
        if (it.frame_start) begin
            receiving = 1'b1;
            rx_count  = 8'd0;
            rx_sum    = 8'd0;
            rx_length = 8'd0;
        end
        if (!receiving)
            return 1'b0;
        if (rx_count < FRAME_CAP)
            frame_buf[rx_count] = it.rx_byte;
        rx_sum   = rx_sum + it.rx_byte;
        rx_count = rx_count + 8'd1;
        if (rx_count == LEN_BYTE_CNT) begin
            rx_length = it.rx_byte;
            if (it.rx_byte < MIN_FRAME_LEN || it.rx_byte > FRAME_CAP)
                close_frame(ERR_LEN);
            return 1'b1;
        end
        if (rx_count < LEN_BYTE_CNT || rx_count != rx_length)
            return 1'b1;
        if (frame_buf[0] != hdr_first_reg || frame_buf[1] != hdr_second_reg)
            code = ERR_HDR;
        else if (rx_sum != 8'd0)
            code = ERR_SUM;
        else
            code = ERR_OK;
        close_frame(code);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side. Payload changes at the falling edge only; a random gap
    // of idle cycles may come first. The item is taken at the first rising
    // edge with in_stall low.
    // ------------------------------------------------------------------
    task automatic send_item(rx_item_t it, bit typed, err_t code, logic reset_req);
        frame_result_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        func        = it.func;
        rx_byte     = it.rx_byte;
        frame_start = it.frame_start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (receive_item(it))
            live_items++;
        foreach (step_results[i])
            if (!(typed && step_results[i].kind == KIND_STATUS))
                results_due.push_back(step_results[i]);
        if (typed) begin
            res = '{KIND_STATUS, 8'h00, 8'h00, code, reset_req, 1'b1};
            results_due.push_back(res);
        end
    endtask

    task automatic send_rx(rx_item_t it);
        send_item(it, 1'b0, ERR_OK, 1'b0);
    endtask

    task automatic send_tick();
        send_rx('{FUNC_TICK, 8'($urandom_range(255)), 1'($urandom_range(1))});
    endtask

    // Pressure point: hold the input until every result is out.
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_HDR_FIRST:  hdr_first_reg  = value;
            CFG_HDR_SECOND: hdr_second_reg = value;
            CFG_SIL_RELOAD: sil_reload_reg = value;
            CFG_REINIT_THR: reinit_thr_reg = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Register writes go in only once results have drained and the
    // block has had time to finish anything that yields no result.
    task automatic reconfigure(logic [7:0] first, logic [7:0] second,
                               logic [7:0] reload, logic [7:0] thr);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_HDR_FIRST,  first);
        write_reg(CFG_HDR_SECOND, second);
        write_reg(CFG_SIL_RELOAD, reload);
        write_reg(CFG_REINIT_THR, thr);
    endtask

    // One frame, mostly well formed. Byte 3 is the checksum slot and is
    // chosen so the frame sums to zero before any damage is applied.
    task automatic send_random_frame();
        logic [7:0] body [FRAME_CAP];
        logic [7:0] acc;
        int         len;
        int         n_send;
        int         pick;
        int         idx;
        pick = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(17, FRAME_CAP)
                                        : $urandom_range(4, 16);
        for (int i = 0; i < FRAME_CAP; i++)
            body[i] = 8'($urandom_range(255));
        body[0] = hdr_first_reg;
        body[1] = hdr_second_reg;
        body[2] = 8'(len);
        acc = 8'd0;
        for (int i = 0; i < len; i++)
            if (i != 3)
                acc = acc + body[i];
        body[3] = 8'd0 - acc;
        n_send = len;
        if (pick < 60) begin
            // good frame
        end else if (pick < 70) begin
            idx = $urandom_range(1);
            body[idx] = body[idx] ^ 8'($urandom_range(1, 255));
        end else if (pick < 80) begin
            body[3] = body[3] + 8'($urandom_range(1, 255));
        end else if (pick < 88) begin
            body[2] = $urandom_range(1) ? 8'($urandom_range(0, MIN_FRAME_LEN - 1))
                                        : 8'($urandom_range(FRAME_CAP + 1, 255));
            n_send = 3;
        end else begin
            // cut short; the next frame start throws it away
            n_send = $urandom_range(1, len - 1);
        end
        for (int i = 0; i < n_send; i++) begin
            if ($urandom_range(99) < 6)
                send_tick();
            send_rx('{FUNC_BYTE, body[i], (i == 0)});
        end
        // line silence and stray bytes between frames
        if ($urandom_range(99) < 25)
            repeat ($urandom_range(1, 24)) send_tick();
        if ($urandom_range(99) < 10)
            repeat ($urandom_range(1, 3)) send_rx('{FUNC_BYTE, 8'($urandom_range(255)), 1'b0});
    endtask

    task automatic run_random(int target);
        int  base;
        bit  paused;
        base   = live_items;
        paused = 1'b0;
        while (live_items - base < target) begin
            send_random_frame();
            if (!paused && live_items - base >= target / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
        end
    endtask

    // Receiver stall pattern, redrawn every cycle.
    always @(negedge clk)
        out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // ------------------------------------------------------------------
    // Output check: every taken item against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        frame_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                fail_count++;
                if (reported < REPORT_MAX) begin
                    reported++;
                    $display("%0t: unexpected item kind=%0d addr=%02h data=%02h err=%0d",
                             $realtime, kind, write_addr, write_data, status_code);
                end
            end else begin
                want = results_due.pop_front();
                if (kind !== want.kind || write_addr !== want.write_addr ||
                    write_data !== want.write_data || status_code !== want.status_code ||
                    link_reset !== want.link_reset || last !== want.last) begin
                    fail_count++;
                    if (reported < REPORT_MAX) begin
                        reported++;
                        $display("%0t: expected kind=%0d addr=%02h data=%02h err=%0d rst=%0d last=%0d",
                                 $realtime, want.kind, want.write_addr, want.write_data,
                                 want.status_code, want.link_reset, want.last);
                        $display("%0t:      got kind=%0d addr=%02h data=%02h err=%0d rst=%0d last=%0d",
                                 $realtime, kind, write_addr, write_data, status_code,
                                 link_reset, last);
                    end
                end
                if (want.kind == KIND_WRITE)
                    writes_seen++;
                else begin
                    status_seen[want.status_code]++;
                    if (want.link_reset)
                        resets_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset register values, no idling on either side.
        for (int r = 0; r < DIR_ROWS; r++)
            send_item('{dir_script[r].func, dir_script[r].rx_byte, dir_script[r].frame_start},
                      dir_script[r].typed, dir_script[r].code, dir_script[r].reset_req);
        run_random(PHASE_ITEMS);

        // Sender mostly idle; reload is zero and the threshold is at its top, so every frame asks
        // for a link reset. Out-of-range indexes must not land anywhere.
        send_gap_pct = 80;
        reconfigure(8'h00, 8'hff, 8'h00, 8'hff);
        write_reg(CFG_IDX_SPARE, 8'h00);
        run_random(PHASE_ITEMS);

        // Receiver mostly stalling; threshold zero never asks for a reset.
        send_gap_pct = 0;
        stall_pct    = 80;
        reconfigure(8'hff, 8'h00, 8'hff, 8'h00);
        write_reg(CFG_IDX_TOP, 8'hff);
        run_random(PHASE_ITEMS);

        // Both sides idle now and then, random headers and counter limits.
        send_gap_pct = 30;
        stall_pct    = 30;
        reconfigure(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(0, 40)), 8'($urandom_range(0, 30)));
        write_reg(CFG_IDX_SPARE, 8'($urandom_range(255)));
        run_random(PHASE_ITEMS);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (results_due.size() != 0) begin
            fail_count += results_due.size();
            $display("%0d expected items never came out", results_due.size());
        end

        $display("covered %0d live input items over four register settings and idle mixes",
                 live_items);
        $display("frames ended ok %0d, header %0d, checksum %0d, length %0d; %0d writes, %0d link resets",
                 status_seen[ERR_OK], status_seen[ERR_HDR], status_seen[ERR_SUM],
                 status_seen[ERR_LEN], writes_seen, resets_seen);
        if (fail_count == 0)
            $display("checksummed_write_frame_receiver_top: match");
        else
            $display("checksummed_write_frame_receiver_top: mismatch");
        $finish;
    end

    // Hang guard, far above the slowest legal run.
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d items still expected", results_due.size());
        $display("checksummed_write_frame_receiver_top: mismatch");
        $finish;
    end

endmodule
